>>> rtl/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg: shared types and constants for the indexed array list unit
// Sizes of the element store, field widths, command and status codes and
// the sequencer state encoding.
// ----------------------------------------------------------------------------
package ial_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LEN_W    = $clog2(CAPACITY + 1);

   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int WORD_W   = 32;
   localparam int STAT_W   = 2;
   localparam int LENGTH_W = 9;

   // wide enough for position, count and count plus two
   localparam int CMP_W = (POS_W > LEN_W + 1) ? POS_W : LEN_W + 1;

   localparam logic [LEN_W-1:0]    CAP_LEN    = LEN_W'(CAPACITY);
   localparam logic [LENGTH_W-1:0] CAP_LENGTH = LENGTH_W'(CAPACITY);

   typedef enum logic [CMD_W-1:0] {
      CMD_GET    = 3'd0,
      CMD_SET    = 3'd1,
      CMD_APPEND = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_REMOVE = 3'd4
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SHIFT_UP,
      S_INS_WRITE,
      S_SHIFT_DN,
      S_DONE
   } state_type;

endpackage

>>> rtl/indexed_array_list_unit.sv
// ----------------------------------------------------------------------------
// indexed_array_list_unit: fixed-capacity ordered list of signed words
// Get, set, append, insert and remove on a list held in one synchronous RAM,
// with insert and remove shifting the later entries one word per cycle.
// ----------------------------------------------------------------------------
//
//   channel  direction  ports                                     meaning
//   req_     in         req_command, req_position, req_word_in    one command
//   rsp_     out        rsp_word_out, rsp_status, rsp_length      its result
//
// Sequence: set, append, unused codes and any rejected command go straight
// to the done state, which loads the result register; get passes through a
// read state; insert shifts the later words up from the tail, then writes the
// new word; remove reads the word, then shifts the later words down. The shift
// loop is bound by the single RAM write port: one word moves per cycle.
// Reset: synchronous, clears the sequencer, the length and the result valid.
// RAM contents are not cleared; every entry below the length has been written.
// Stalls: a new command is taken whenever the sequencer is idle, even while
// the previous result waits; the next result holds until that one is taken.
//
module indexed_array_list_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [ial_pkg::CMD_W-1:0]     req_command,
   input  logic [ial_pkg::POS_W-1:0]     req_position,
   input  logic signed [ial_pkg::WORD_W-1:0] req_word_in,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [ial_pkg::WORD_W-1:0] rsp_word_out,
   output logic [ial_pkg::STAT_W-1:0]    rsp_status,
   output logic [ial_pkg::LENGTH_W-1:0]  rsp_length
);
   import ial_pkg::*;

   // sequencer and transaction context
   state_type               state_ff,  state_in;
   cmd_type                 cmd_ff,    cmd_in;
   logic [ADDR_W-1:0]       pos_ff,    pos_in;
   logic [WORD_W-1:0]       word_ff,   word_in;
   logic [ADDR_W-1:0]       idx_ff,    idx_in;
   logic [LEN_W-1:0]        count_ff,  count_in;
   logic [WORD_W-1:0]       res_word_ff,   res_word_in;
   status_type              res_status_ff, res_status_in;

   // result register
   logic                    rsp_valid_ff,  rsp_valid_in;
   logic [WORD_W-1:0]       rsp_word_ff,   rsp_word_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [LENGTH_W-1:0]     rsp_length_ff, rsp_length_in;

   // RAM access
   logic                    ram_we;
   logic [ADDR_W-1:0]       ram_waddr;
   logic [WORD_W-1:0]       ram_wdata;
   logic                    ram_re;
   logic [ADDR_W-1:0]       ram_raddr;
   logic [WORD_W-1:0]       ram_rdata;

   logic                    req_fire;
   logic                    range_err;
   logic                    list_full;

   ial_ram #(
      .DEPTH (CAPACITY),
      .WIDTH (WORD_W),
      .ADDR_W(ADDR_W)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign range_err = CMP_W'(req_position) >= CMP_W'(count_ff);
   assign list_full = (count_ff == CAP_LEN);

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      word_in       = word_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      res_word_in   = res_word_ff;
      res_status_in = res_status_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_word_in   = rsp_word_ff;
      rsp_status_in = rsp_status_ff;
      rsp_length_in = rsp_length_ff;

      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = ram_rdata;
      ram_re    = 1'b0;
      ram_raddr = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in        = cmd_type'(req_command);
               pos_in        = ADDR_W'(req_position);
               word_in       = req_word_in;
               res_word_in   = '0;
               res_status_in = ST_OK;
               state_in      = S_DONE;
               unique case (req_command)
                  CMD_GET: begin
                     if (range_err) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        // fetch the word; it returns next cycle
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(req_position);
                        state_in  = S_READ;
                     end
                  end
                  CMD_SET: begin
                     if (range_err) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(req_position);
                        ram_wdata = req_word_in;
                     end
                  end
                  CMD_APPEND: begin
                     if (list_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ram_we    = 1'b1;
                        ram_waddr = ADDR_W'(count_ff);
                        ram_wdata = req_word_in;
                        count_in  = count_ff + LEN_W'(1);
                     end
                  end
                  CMD_INSERT: begin
                     // index check comes before the full check
                     if (range_err) begin
                        res_status_in = ST_RANGE;
                     end else if (list_full) begin
                        res_status_in = ST_FULL;
                     end else begin
                        // walk down from the tail: read last, write one above
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(count_ff - LEN_W'(1));
                        idx_in    = ADDR_W'(count_ff);
                        state_in  = S_SHIFT_UP;
                     end
                  end
                  CMD_REMOVE: begin
                     if (range_err) begin
                        res_status_in = ST_RANGE;
                     end else begin
                        ram_re    = 1'b1;
                        ram_raddr = ADDR_W'(req_position);
                        state_in  = S_READ;
                     end
                  end
                  default: begin
                     // unused codes: no effect, ok status
                  end
               endcase
            end
         end

         S_READ: begin
            res_word_in = ram_rdata;
            state_in    = S_DONE;
            if (cmd_ff == CMD_REMOVE) begin
               if (CMP_W'(pos_ff) + CMP_W'(1) < CMP_W'(count_ff)) begin
                  // pull the next word down into the hole
                  ram_re    = 1'b1;
                  ram_raddr = pos_ff + ADDR_W'(1);
                  idx_in    = pos_ff;
                  state_in  = S_SHIFT_DN;
               end else begin
                  count_in = count_ff - LEN_W'(1);
               end
            end
         end

         S_SHIFT_UP: begin
            // write the word read last cycle one slot higher
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            if (idx_ff - ADDR_W'(1) == pos_ff) begin
               state_in = S_INS_WRITE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff - ADDR_W'(2);
               idx_in    = idx_ff - ADDR_W'(1);
            end
         end

         S_INS_WRITE: begin
            ram_we    = 1'b1;
            ram_waddr = pos_ff;
            ram_wdata = word_ff;
            count_in  = count_ff + LEN_W'(1);
            state_in  = S_DONE;
         end

         S_SHIFT_DN: begin
            // write the word read last cycle one slot lower
            ram_we    = 1'b1;
            ram_waddr = idx_ff;
            ram_wdata = ram_rdata;
            if (CMP_W'(idx_ff) + CMP_W'(2) < CMP_W'(count_ff)) begin
               ram_re    = 1'b1;
               ram_raddr = idx_ff + ADDR_W'(2);
               idx_in    = idx_ff + ADDR_W'(1);
            end else begin
               count_in = count_ff - LEN_W'(1);
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = res_word_ff;
               rsp_status_in = res_status_ff;
               rsp_length_in = LENGTH_W'(count_ff);
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      word_ff       <= word_in;
      idx_ff        <= idx_in;
      res_word_ff   <= res_word_in;
      res_status_ff <= res_status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_word_out = rsp_word_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_length   = rsp_length_ff;

endmodule

>>> rtl/ial_ram.sv
// ----------------------------------------------------------------------------
// ial_ram: simple dual-port synchronous RAM
// One write port and one read port; read data registered.
// ----------------------------------------------------------------------------
module ial_ram #(
   parameter int DEPTH  = 256,
   parameter int WIDTH  = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ial_checker.sv
// ----------------------------------------------------------------------------
// ial_checker: port-level checks for the indexed array list unit
// Watches the result channel for legal status codes, length bounds and
// stable results under backpressure.
// ----------------------------------------------------------------------------
module ial_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [ial_pkg::WORD_W-1:0] rsp_word_out,
   input logic [ial_pkg::STAT_W-1:0]        rsp_status,
   input logic [ial_pkg::LENGTH_W-1:0]      rsp_length
);
   import ial_pkg::*;

   // no result may appear out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_OK || rsp_status == ST_RANGE ||
                     rsp_status == ST_FULL))
      else $error("illegal status code");

   // a full rejection only happens at capacity
   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> rsp_length == CAP_LENGTH)
      else $error("full status below capacity");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= CAP_LENGTH)
      else $error("length beyond capacity");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_word_out) &&
                                     $stable(rsp_status) && $stable(rsp_length)))
      else $error("stalled result changed");

endmodule

bind indexed_array_list_unit ial_checker u_ial_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_word_out(rsp_word_out),
   .rsp_status  (rsp_status),
   .rsp_length  (rsp_length)
);
